### sv/pmd_pkg.sv
package pmd_pkg;

  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned IntegW  = 40;

  localparam logic [12:0] PWM_MAX = 13'd5000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_COUNT    = 3'd0,
    REG_KP_GAIN         = 3'd1,
    REG_KI_GAIN         = 3'd2,
    REG_VOLTAGE_LIMIT   = 3'd3,
    REG_DEADBAND_VOLTS  = 3'd4,
    REG_PWM_PER_VOLT    = 3'd5,
    REG_DEAD_ZONE_PWM   = 3'd6,
    REG_DEAD_ZONE_VOLTS = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_e;

  // Request to the shared multiplier: operands are already sign or zero extended.
  typedef struct packed {
    logic                   en;
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } mul_req_t;

endpackage

### sv/pi_position_motor_drive.sv
// PI position controller for an H-bridge motor drive.
//
// Input channel: in_valid_i / in_stall_o carry one encoder_count word per
// control tick. A word is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word (duty, direction, control and compensated volts, error, count delta).
// Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// cfg_ready_o is always high. Write registers only while the block is idle.
//
// Sequencing: one shared 33x33 multiplier is stepped by a ten-step sequencer
// (two gain products, two halves of the PWM scaling, adds and compares in
// between). The block takes no new word until the sequencer is back in idle,
// that is, until the last step has loaded the result register.
// A finished result sits in the output register; the next word may be taken
// meanwhile, and its result waits in the last step until the register frees.
// Reset clears the integral, the previous count and the handshakes, and loads
// the default gains, limits and dead-zone settings.
module pi_position_motor_drive
  import pmd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input words
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        encoder_count_i,
  // result words
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [12:0]               pwm_duty_o,
  output logic [1:0]                direction_o,
  output logic signed [23:0]        control_volts_o,
  output logic signed [31:0]        compensated_volts_o,
  output logic signed [31:0]        position_error_o,
  output logic signed [31:0]        count_delta_o,
  // configuration writes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDatW-1:0]        cfg_data_i
);

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MKI  = 4'd1;  // ki * error
  localparam logic [3:0] S_ITG  = 4'd2;  // tentative integral, saturated
  localparam logic [3:0] S_MKP  = 4'd3;  // kp * error
  localparam logic [3:0] S_SUM  = 4'd4;  // u = kp*e + integral
  localparam logic [3:0] S_ABS  = 4'd5;  // |u|
  localparam logic [3:0] S_LIM  = 4'd6;  // anti-windup and deadband
  localparam logic [3:0] S_MLO  = 4'd7;  // low half of |u| * pwm_per_volt
  localparam logic [3:0] S_MHI  = 4'd8;  // high half
  localparam logic [3:0] S_CNT  = 4'd9;  // PWM count
  localparam logic [3:0] S_FIN  = 4'd10; // dead zone, clamps, load output

  localparam logic signed [63:0] Int40Max = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] Int40Min = -Int40Max - 64'sd1;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic signed [31:0] target_q;
  logic [30:0] kp_q, ki_q, lim_q, db_q, ppv_q, dzv_q;
  logic [12:0] dzp_q;

  // loop state
  logic [31:0]        prev_q;
  logic [IntegW-1:0]  integ_q;

  // per-tick working registers
  logic signed [31:0] err_q, delta_q;
  logic [IntegW-1:0]  itent_q;
  logic signed [63:0] u_q;
  logic [63:0]        mag_q;
  logic               neg_q;
  logic [31:0]        carry_q;
  logic [55:0]        cnt_q;

  // output register
  logic        out_valid_q;
  logic [12:0] duty_q;
  logic [1:0]  dir_q;
  logic signed [23:0] cv_q;
  logic signed [31:0] comp_q, oerr_q, odelta_q;

  mul_req_t         mreq;
  logic [ProdW-1:0] prod;

  logic in_acc, out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  pmd_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  // Steer the shared multiplier.
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = '0;
    mreq.b  = '0;
    unique case (state_q)
      S_MKI: begin
        mreq.en = 1'b1;
        mreq.a  = {err_q[31], err_q};
        mreq.b  = {2'b00, ki_q};
      end
      S_MKP: begin
        mreq.en = 1'b1;
        mreq.a  = {err_q[31], err_q};
        mreq.b  = {2'b00, kp_q};
      end
      S_MLO: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, mag_q[31:0]};
        mreq.b  = {2'b00, ppv_q};
      end
      S_MHI: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, mag_q[63:32]};
        mreq.b  = {2'b00, ppv_q};
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MKI;
      S_MKI:   state_d = S_ITG;
      S_ITG:   state_d = S_MKP;
      S_MKP:   state_d = S_SUM;
      S_SUM:   state_d = S_ABS;
      S_ABS:   state_d = S_LIM;
      S_LIM:   state_d = S_MLO;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_CNT;
      S_CNT:   state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath arithmetic for the non-multiply steps
  logic signed [63:0] isum, usum;
  logic [63:0]        cnt_sum;
  logic [56:0]        cnt_dz;
  logic               cnt_zero, pwm_sat;
  logic [63:0]        comp_mag;
  logic [55:0]        mag8;
  logic [12:0]        duty_d;
  logic [1:0]         dir_d;
  logic signed [23:0] cv_d;
  logic signed [31:0] comp_d;
  logic [IntegW-1:0]  itent_d;

  assign isum = $signed({{(64-IntegW){integ_q[IntegW-1]}}, integ_q}) + $signed(prod);
  assign usum = $signed(prod) + $signed({{(64-IntegW){itent_q[IntegW-1]}}, itent_q});
  assign cnt_sum = prod + {32'd0, carry_q};

  // Saturate the tentative integral to the signed 40-bit range.
  always_comb begin
    if (isum > Int40Max) begin
      itent_d = Int40Max[IntegW-1:0];
    end else if (isum < Int40Min) begin
      itent_d = Int40Min[IntegW-1:0];
    end else begin
      itent_d = isum[IntegW-1:0];
    end
  end

  assign cnt_dz   = {1'b0, cnt_q} + {44'd0, dzp_q};
  assign cnt_zero = (cnt_q == 56'd0);
  assign pwm_sat  = (cnt_dz > {44'd0, PWM_MAX});
  assign mag8     = mag_q[63:8];

  always_comb begin
    // magnitude of the compensated control before the 32-bit clamp
    if (cnt_zero) begin
      comp_mag = mag_q;
    end else if (pwm_sat) begin
      comp_mag = {33'd0, lim_q};
    end else begin
      comp_mag = mag_q + {33'd0, dzv_q};
    end

    if (neg_q) begin
      comp_d = (comp_mag > 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                    : -$signed(comp_mag[31:0]);
      cv_d   = (mag8 > 56'h80_0000) ? 24'sh80_0000 : -$signed(mag8[23:0]);
    end else begin
      comp_d = (comp_mag > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                    : $signed(comp_mag[31:0]);
      cv_d   = (mag8 > 56'h7F_FFFF) ? 24'sh7F_FFFF : $signed(mag8[23:0]);
    end

    if (cnt_zero) begin
      duty_d = 13'd0;
      dir_d  = DIR_STOP;
    end else begin
      duty_d = pwm_sat ? PWM_MAX : cnt_dz[12:0];
      dir_d  = neg_q ? DIR_BWD : DIR_FWD;
    end
  end

  // Control state: sequencer, loop state, configuration, output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      kp_q        <= 31'd308838;
      ki_q        <= 31'd772;
      lim_q       <= 31'd251658240;
      db_q        <= 31'd838861;
      ppv_q       <= 31'd21845333;
      dzp_q       <= 13'd850;
      dzv_q       <= 31'd42781901;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_TARGET_COUNT:    target_q <= $signed(cfg_data_i);
          REG_KP_GAIN:         kp_q     <= cfg_data_i[30:0];
          REG_KI_GAIN:         ki_q     <= cfg_data_i[30:0];
          REG_VOLTAGE_LIMIT:   lim_q    <= cfg_data_i[30:0];
          REG_DEADBAND_VOLTS:  db_q     <= cfg_data_i[30:0];
          REG_PWM_PER_VOLT:    ppv_q    <= cfg_data_i[30:0];
          REG_DEAD_ZONE_PWM:   dzp_q    <= cfg_data_i[12:0];
          REG_DEAD_ZONE_VOLTS: dzv_q    <= cfg_data_i[30:0];
          default:             ;
        endcase
      end

      if (in_acc) begin
        prev_q <= encoder_count_i;
      end

      // Keep the increment only when |u| stays within the limit.
      if (state_q == S_LIM && !(mag_q > {33'd0, lim_q})) begin
        integ_q <= itent_q;
      end

      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q   <= target_q - encoder_count_i;
      delta_q <= encoder_count_i - prev_q;
    end
    if (state_q == S_ITG) begin
      itent_q <= itent_d;
    end
    if (state_q == S_SUM) begin
      u_q <= usum;
    end
    if (state_q == S_ABS) begin
      mag_q <= u_q[63] ? 64'(-u_q) : 64'(u_q);
      neg_q <= u_q[63];
    end
    // Drop magnitudes inside the deadband.
    if (state_q == S_LIM && mag_q < {33'd0, db_q}) begin
      mag_q <= '0;
      neg_q <= 1'b0;
    end
    if (state_q == S_MHI) begin
      carry_q <= prod[63:32];
    end
    if (state_q == S_CNT) begin
      cnt_q <= cnt_sum[63:8];
    end
    if (state_q == S_FIN && out_free) begin
      duty_q   <= duty_d;
      dir_q    <= dir_d;
      cv_q     <= cv_d;
      comp_q   <= comp_d;
      oerr_q   <= err_q;
      odelta_q <= delta_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pwm_duty_o          = duty_q;
  assign direction_o         = dir_q;
  assign control_volts_o     = cv_q;
  assign compensated_volts_o = comp_q;
  assign position_error_o    = oerr_q;
  assign count_delta_o       = odelta_q;

  // A taken word always starts the multiply sequence.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MKI))
    else $error("sequencer did not start on a taken word");

  // Drive magnitude never exceeds the PWM period.
  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pwm_duty_o <= PWM_MAX))
    else $error("pwm duty above PWM_MAX");

  // Stop direction goes with zero duty and nothing else.
  a_dir_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((direction_o == DIR_STOP) == (pwm_duty_o == 13'd0)))
    else $error("direction and duty disagree");

  // A result is loaded only from the last step.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o ##1 out_valid_o) |-> ($past(state_q) == S_FIN))
    else $error("result loaded outside the final step");

endmodule

### sv/pmd_mul.sv
module pmd_mul
  import pmd_pkg::*;
(
  input  logic             clk_i,
  input  mul_req_t         req_i,
  output logic [ProdW-1:0] prod_o
);

  logic signed [2*MulW-1:0] full;
  logic        [ProdW-1:0]  prod_q;

  assign full = req_i.a * req_i.b;

  // Hold the product until the next request.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= full[ProdW-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

### verif/pi_position_motor_drive_tb.sv
module pi_position_motor_drive_tb;
  import pmd_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 5;
  localparam int TailCycles  = 24;     // quiet margin after the last owed result
  localparam int HoldCycles  = 300;    // long receiver hold-off, fills the block
  localparam int LimitCycles = 200000;
  localparam int Phases      = 8;
  localparam int PhaseWords  = 100;
  localparam int ReportMax   = 10;

  localparam longint Int40Max = 64'sd549755813887;
  localparam longint Int40Min = -Int40Max - 1;

  // One result word as the block presents it.
  typedef struct packed {
    logic [12:0]        duty;
    dir_e               dir;
    logic signed [23:0] cv;
    logic signed [31:0] comp;
    logic signed [31:0] err;
    logic signed [31:0] delta;
  } drive_word_t;

  // One row of the directed plan: a register write or an encoder word, the
  // latter optionally with a hand-worked result.
  typedef struct packed {
    logic        is_write;
    cfg_reg_e    idx;
    logic [31:0] data;
    logic        fixed;
    drive_word_t want;
  } plan_row_t;

  // How a register value is drawn for a random phase.
  typedef enum logic [1:0] {
    PICK_MIN,
    PICK_MAX,
    PICK_TYPICAL,
    PICK_ANY
  } pick_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] encoder_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [12:0]        pwm_duty_o;
  logic [1:0]         direction_o;
  logic signed [23:0] control_volts_o;
  logic signed [31:0] compensated_volts_o;
  logic signed [31:0] position_error_o;
  logic signed [31:0] count_delta_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  // Controller state and settings as the block should hold them after reset.
  logic signed [31:0] tgt      = '0;
  bit [30:0]          kp       = 31'd308838;
  bit [30:0]          ki       = 31'd772;
  bit [30:0]          vlim     = 31'd251658240;
  bit [30:0]          dband    = 31'd838861;
  bit [30:0]          ppv      = 31'd21845333;
  bit [12:0]          dzp      = 13'd850;
  bit [30:0]          dzv      = 31'd42781901;
  logic [31:0]        prev_enc = '0;
  longint             integ    = 0;

  drive_word_t pending_ticks[$];   // results owed by the block, oldest first
  plan_row_t   plan[$];
  int          failures = 0;
  int          results_seen = 0;
  bit          no_idle = 1'b0;     // both sides run flat out while set
  bit          hold_off = 1'b0;    // ask the receiver for one long stall

  pi_position_motor_drive i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .encoder_count_i     (encoder_count_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .pwm_duty_o          (pwm_duty_o),
    .direction_o         (direction_o),
    .control_volts_o     (control_volts_o),
    .compensated_volts_o (compensated_volts_o),
    .position_error_o    (position_error_o),
    .count_delta_o       (count_delta_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Mirror a register write into the local copy of the settings.
  function automatic void set_reg(cfg_reg_e r, logic [31:0] d);
    case (r)
      REG_TARGET_COUNT:    tgt = d;
      REG_KP_GAIN:         kp = d[30:0];
      REG_KI_GAIN:         ki = d[30:0];
      REG_VOLTAGE_LIMIT:   vlim = d[30:0];
      REG_DEADBAND_VOLTS:  dband = d[30:0];
      REG_PWM_PER_VOLT:    ppv = d[30:0];
      REG_DEAD_ZONE_PWM:   dzp = d[12:0];
      REG_DEAD_ZONE_VOLTS: dzv = d[30:0];
      default: ;
    endcase
  endfunction

  // One control tick: PI law with anti-windup, deadband, PWM scaling and
  // dead-zone compensation. Advances the previous count and the integral.
  function automatic drive_word_t control_tick(logic [31:0] enc);
    logic [31:0] err_b, dlt_b;
    longint      e, itent, u, lim, cv, comp;
    logic [63:0] mag, cnt, hi, lo;
    drive_word_t w;
    err_b = tgt - enc;
    dlt_b = enc - prev_enc;
    prev_enc = enc;
    e = longint'($signed(err_b));
    lim = longint'(vlim);

    // Saturate the tentative integral to 40 bits; keep it only when the
    // output stays within the limit (equal to the limit still counts).
    itent = clip(integ + longint'(ki) * e, Int40Min, Int40Max);
    u = longint'(kp) * e + itent;
    if (u >= -lim && u <= lim) integ = itent;

    if (u < 0) mag = -u;
    else mag = u;
    // Strict deadband: a magnitude equal to the band survives.
    if (mag < 64'(dband)) begin
      u = 0;
      mag = 0;
    end

    cv = longint'(mag >> 8);
    if (u < 0) cv = -cv;
    cv = clip(cv, -64'sd8388608, 64'sd8388607);

    // Scale to PWM counts in two halves so nothing overflows 64 bits.
    hi = mag >> 32;
    lo = {32'd0, mag[31:0]};
    cnt = (hi * ppv + ((lo * ppv) >> 32)) >> 8;

    w.duty = '0;
    w.dir = DIR_STOP;
    if (cnt == 0) begin
      comp = u;
    end else begin
      cnt = cnt + dzp;
      w.dir = (u < 0) ? DIR_BWD : DIR_FWD;
      if (cnt > PWM_MAX) begin
        w.duty = PWM_MAX;
        comp = (u < 0) ? -lim : lim;
      end else begin
        w.duty = cnt[12:0];
        comp = (u < 0) ? u - longint'(dzv) : u + longint'(dzv);
      end
    end
    comp = clip(comp, -64'sd2147483648, 64'sd2147483647);

    w.cv = cv[23:0];
    w.comp = comp[31:0];
    w.err = err_b;
    w.delta = dlt_b;
    return w;
  endfunction

  function automatic drive_word_t known(logic [12:0] duty, dir_e dir, logic [23:0] cv,
                                        logic [31:0] comp, logic [31:0] err,
                                        logic [31:0] delta);
    drive_word_t w;
    w.duty = duty;
    w.dir = dir;
    w.cv = cv;
    w.comp = comp;
    w.err = err;
    w.delta = delta;
    return w;
  endfunction

  // Draw a register value for a random phase.
  function automatic logic [31:0] reg_value(cfg_reg_e r, pick_e p);
    case (p)
      PICK_MIN: return (r == REG_TARGET_COUNT) ? 32'h8000_0000 : 32'd0;
      PICK_MAX: begin
        if (r == REG_TARGET_COUNT) return 32'h7FFF_FFFF;
        if (r == REG_DEAD_ZONE_PWM) return 32'(PWM_MAX);
        return 32'h7FFF_FFFF;
      end
      PICK_ANY: return (r == REG_DEAD_ZONE_PWM) ? $urandom_range(0, 5000) : $urandom;
      default: begin
        case (r)
          REG_TARGET_COUNT:    return 32'(int'($urandom_range(0, 40000)) - 20000);
          REG_KP_GAIN:         return $urandom_range(0, 1000000);
          REG_KI_GAIN:         return $urandom_range(0, 5000);
          REG_VOLTAGE_LIMIT:   return $urandom_range(1 << 22, 1 << 29);
          REG_DEADBAND_VOLTS:  return $urandom_range(0, 1 << 22);
          REG_PWM_PER_VOLT:    return $urandom_range(1 << 20, 1 << 26);
          REG_DEAD_ZONE_PWM:   return $urandom_range(0, 2000);
          default:             return $urandom_range(0, 1 << 27);
        endcase
      end
    endcase
  endfunction

  task automatic add_write(cfg_reg_e r, logic [31:0] d);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.idx = r;
    row.data = d;
    plan.push_back(row);
  endtask

  task automatic add_word(logic [31:0] enc);
    plan_row_t row;
    row = '0;
    row.data = enc;
    plan.push_back(row);
  endtask

  task automatic add_known(logic [31:0] enc, drive_word_t want);
    plan_row_t row;
    row = '0;
    row.data = enc;
    row.fixed = 1'b1;
    row.want = want;
    plan.push_back(row);
  endtask

  // Write one register. Valid stays high afterwards so that back-to-back
  // writes need no lowering; the next encoder word drops it.
  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_reg(r, d);
  endtask

  // Offer one encoder word after a random gap and hold it until taken.
  task automatic push_word(logic [31:0] enc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    encoder_count_i <= enc;
    do @(posedge clk_i); while (in_stall_o);
    pending_ticks.push_back(control_tick(enc));
  endtask

  // Drop valid, drain every owed result, then let the pipeline go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_ticks.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic choose_settings(int ph);
    pick_e p;
    int    roll;
    for (int r = 0; r < 8; r++) begin
      roll = $urandom_range(0, 99);
      if (ph == 0) p = PICK_TYPICAL;
      else if (ph == 1) p = PICK_MAX;
      else if (ph == 3) p = PICK_MIN;
      else if (roll < 60) p = PICK_TYPICAL;
      else if (roll < 75) p = PICK_ANY;
      else if (roll < 88) p = PICK_MIN;
      else p = PICK_MAX;
      write_reg(cfg_reg_e'(r), reg_value(cfg_reg_e'(r), p));
    end
  endtask

  // Mostly moves that settle towards the target from some offset (with
  // overshoot and jitter), sprinkled with full-range noise words.
  task automatic run_phase(int words);
    int     left, steps, k;
    longint pos, off;
    left = words;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word($urandom);
        left--;
      end else begin
        case ($urandom_range(0, 3))
          0: off = longint'($urandom_range(0, 64)) - 32;
          1: off = longint'($urandom_range(0, 8192)) - 4096;
          2: off = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          default: off = longint'($signed($urandom));
        endcase
        pos = longint'(tgt) + off;
        steps = $urandom_range(4, 24);
        while (steps > 0 && left > 0) begin
          push_word(pos[31:0]);
          left--;
          steps--;
          k = int'($urandom_range(0, 10)) - 4;
          pos = longint'(tgt) + ((pos - longint'(tgt)) * k) / 8
                + longint'($urandom_range(0, 6)) - 3;
        end
      end
    end
  endtask

  task automatic note_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      failures++;
      if (failures <= ReportMax)
        $display("result word %0d: %s expected %0d, got %0d", results_seen, name,
                 $signed(want), $signed(seen));
    end
  endtask

  // Reset: hold low at the start, release once and never again.
  initial begin : reset_seq
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: stall for a random number of cycles ahead of every word, or
  // for one long stretch when asked, then take the next word.
  initial begin : result_sink
    int n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 5);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every word taken on the result side with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    drive_word_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.duty = pwm_duty_o;
      seen.dir = dir_e'(direction_o);
      seen.cv = control_volts_o;
      seen.comp = compensated_volts_o;
      seen.err = position_error_o;
      seen.delta = count_delta_o;
      if (pending_ticks.size() == 0) begin
        failures++;
        if (failures <= ReportMax)
          $display("result word %0d arrived with none owed", results_seen);
      end else begin
        want = pending_ticks.pop_front();
        note_field("pwm_duty", want.duty, seen.duty);
        note_field("direction", want.dir, seen.dir);
        note_field("control_volts", want.cv, seen.cv);
        note_field("compensated_volts", want.comp, seen.comp);
        note_field("position_error", want.err, seen.err);
        note_field("count_delta", want.delta, seen.delta);
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    bit writing;
    writing = 1'b0;

    // Straight after reset: at rest, then full drive either way (output
    // clamped, integral step undone), then back to rest.
    add_known(32'd0, known(13'd0, DIR_STOP, 24'd0, 32'd0, 32'd0, 32'd0));
    add_known(-32'sd10000, known(PWM_MAX, DIR_FWD, 24'sd8388607, 32'sd251658240,
                                 32'sd10000, -32'sd10000));
    add_known(32'sd10000, known(PWM_MAX, DIR_BWD, 24'h80_0000, -32'sd251658240,
                                -32'sd10000, 32'sd20000));
    add_known(32'd0, known(13'd0, DIR_STOP, 24'd0, 32'd0, 32'd0, -32'sd10000));

    // Deadband edge: a magnitude equal to the band survives, one below is zeroed.
    add_write(REG_KP_GAIN, 32'd1000);
    add_write(REG_KI_GAIN, 32'd0);
    add_write(REG_DEADBAND_VOLTS, 32'd5000);
    add_word(-32'sd5);
    add_word(-32'sd4);

    // Anti-windup edge: integral climbs to the limit, holds there, and the
    // zero-error word shows what it kept.
    add_write(REG_KP_GAIN, 32'd0);
    add_write(REG_KI_GAIN, 32'd1000);
    add_write(REG_VOLTAGE_LIMIT, 32'd2000);
    add_write(REG_DEADBAND_VOLTS, 32'd0);
    add_word(-32'sd1);
    add_word(-32'sd1);
    add_word(-32'sd1);
    add_word(32'd0);

    // No PWM scaling: the count truncates to zero, so the raw control comes
    // out, saturated to 32 bits; errors at the wrap-around extremes.
    add_write(REG_PWM_PER_VOLT, 32'd0);
    add_write(REG_KP_GAIN, 32'h7FFF_FFFF);
    add_write(REG_KI_GAIN, 32'd0);
    add_write(REG_VOLTAGE_LIMIT, 32'h7FFF_FFFF);
    add_known(32'h8000_0000, known(13'd0, DIR_STOP, 24'h80_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000));
    add_known(32'h7FFF_FFFF, known(13'd0, DIR_STOP, 24'h80_0000, 32'h8000_0000,
                                   32'h8000_0001, 32'hFFFF_FFFF));
    add_write(REG_TARGET_COUNT, 32'h7FFF_FFFF);
    add_known(32'd0, known(13'd0, DIR_STOP, 24'sd8388607, 32'sd2147483647,
                           32'h7FFF_FFFF, 32'h8000_0001));

    // Integral saturation both ways with the integral gain, PWM scaling and dead-zone offsets at their top.
    add_write(REG_KP_GAIN, 32'd0);
    add_write(REG_KI_GAIN, 32'h7FFF_FFFF);
    add_write(REG_PWM_PER_VOLT, 32'h7FFF_FFFF);
    add_write(REG_DEAD_ZONE_PWM, 32'(PWM_MAX));
    add_write(REG_DEAD_ZONE_VOLTS, 32'h7FFF_FFFF);
    add_word(32'd0);
    add_word(32'h7FFF_FFFF);
    add_word(32'hFFFF_FFFF);

    // Back to the power-on tuning: small errors land inside the PWM range
    // and pick up the dead-zone offset.
    add_write(REG_TARGET_COUNT, 32'd1000);
    add_write(REG_KP_GAIN, 32'd308838);
    add_write(REG_KI_GAIN, 32'd772);
    add_write(REG_VOLTAGE_LIMIT, 32'd251658240);
    add_write(REG_DEADBAND_VOLTS, 32'd838861);
    add_write(REG_PWM_PER_VOLT, 32'd21845333);
    add_write(REG_DEAD_ZONE_PWM, 32'd850);
    add_write(REG_DEAD_ZONE_VOLTS, 32'd42781901);
    add_word(32'd900);
    add_word(32'd1100);
    add_word(32'd1000);
    add_word(32'h5555_5555);
    add_word(32'hAAAA_AAAA);

    do @(posedge clk_i); while (!rst_ni);

    // Walk the plan; drain before each group of register writes.
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!writing) settle();
        write_reg(plan[i].idx, plan[i].data);
        writing = 1'b1;
      end else begin
        writing = 1'b0;
        push_word(plan[i].data);
        if (plan[i].fixed) pending_ticks[pending_ticks.size() - 1] = plan[i].want;
      end
    end

    // Random phases, each under fresh settings; some run without gaps and
    // some start with a long receiver hold-off so the input backs up.
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      choose_settings(ph);
      no_idle = (ph % 3 == 2);
      hold_off = (ph == 2 || ph == 6);
      run_phase(PhaseWords);
    end

    settle();
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #(LimitCycles * ClkPeriod);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
